FILE: rtl/assert_macros.svh
// Assertion helpers for the RC4 engine.
// Both macros expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define RC4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rc4 assertion failed");

`define RC4_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rc4 forbidden condition seen");

`else

`define RC4_ASSERT(lbl, prop)

`define RC4_ASSERT_NEVER(lbl, cond)

`endif

`endif

FILE: rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int MAX_KEY_BYTES = 256;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int CNT_W         = $clog2(MAX_KEY_BYTES + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // opcode values
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  // permutation table port
  typedef struct packed {
    logic  clr;
    logic  we;
    idx_t  waddr;
    byte_t wdata;
    idx_t  raddr;
  } perm_req_t;

  // key store port
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    byte_t wdata;
    idx_t  raddr;
  } key_req_t;

  // result handed to the output register
  typedef struct packed {
    logic  vld;
    byte_t cipher;
    byte_t ks;
    logic  last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/rc4_stream_cipher.sv
// RC4 engine. Key byte: stored, dropped once the key store is full. Last key
// byte: scheduling steps KS_RD, KS_J, KS_WN, KS_WJ per entry over the whole
// table (one read and one write port) before the next word. Text byte, one
// at a time: three reads, two writes back to back, result to the output reg.
// Reset (async, active low): table reads as identity, i = j = 0, key empty.
`default_nettype none

`include "assert_macros.svh"

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  opcode_i,
  input  byte_t data_byte_i,
  input  logic  last_flag_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t cipher_byte_o,
  output byte_t keystream_byte_o,
  output logic  last_out_o
);

  perm_req_t perm_req;
  key_req_t  key_req;
  byte_t     perm_rdata;
  byte_t     key_rdata;
  res_t      res;
  logic      out_free;

  logic      out_valid_q;
  byte_t     cipher_q;
  byte_t     ks_q;
  logic      last_q;

  rc4_perm_mem u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (perm_req),
    .rdata_o (perm_rdata)
  );

  rc4_key_mem u_key (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  rc4_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .last_flag_i  (last_flag_i),
    .out_free_i   (out_free),
    .res_o        (res),
    .perm_req_o   (perm_req),
    .perm_rdata_i (perm_rdata),
    .key_req_o    (key_req),
    .key_rdata_i  (key_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.vld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      cipher_q <= res.cipher;
      ks_q     <= res.ks;
      last_q   <= res.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cipher_byte_o    = cipher_q;
  assign keystream_byte_o = ks_q;
  assign last_out_o       = last_q;

  // a new word never overwrites one that is still waiting
  `RC4_ASSERT(a_no_overwrite, res.vld |-> (!out_valid_q || !out_stall_i))
  // table reset and table write never coincide
  `RC4_ASSERT_NEVER(a_clr_we, perm_req.clr && perm_req.we)
  // key store is written only while the table is idle
  `RC4_ASSERT_NEVER(a_key_perm_we, key_req.we && perm_req.we)

endmodule

`default_nettype wire

FILE: rtl/rc4_perm_mem.sv
`default_nettype none

module rc4_perm_mem
  import rc4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  perm_req_t req_i,
  output byte_t     rdata_o
);

  byte_t                 mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_q;
  byte_t                 rd_q;
  idx_t                  raddr_q;
  logic                  rvalid_q;

  // storage, read-first
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q    <= mem[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  // per-entry written flags; an unwritten entry reads as its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[req_i.raddr];
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rd_q : byte_t'(raddr_q);

endmodule

`default_nettype wire

FILE: rtl/rc4_key_mem.sv
`default_nettype none

module rc4_key_mem
  import rc4_pkg::*;
(
  input  logic     clk_i,
  input  key_req_t req_i,
  output byte_t    rdata_o
);

  byte_t mem [TABLE_SIZE];
  byte_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem[req_i.raddr];
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/rc4_core.sv
`default_nettype none

module rc4_core
  import rc4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      opcode_i,
  input  byte_t     data_byte_i,
  input  logic      last_flag_i,
  input  logic      out_free_i,
  output res_t      res_o,
  output perm_req_t perm_req_o,
  input  byte_t     perm_rdata_i,
  output key_req_t  key_req_o,
  input  byte_t     key_rdata_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_KS_RD = 4'd1;
  localparam logic [3:0] ST_KS_J  = 4'd2;
  localparam logic [3:0] ST_KS_WN = 4'd3;
  localparam logic [3:0] ST_KS_WJ = 4'd4;
  localparam logic [3:0] ST_PG_J  = 4'd5;
  localparam logic [3:0] ST_PG_WI = 4'd6;
  localparam logic [3:0] ST_PG_KS = 4'd7;
  localparam logic [3:0] ST_HOLD  = 4'd8;

  localparam cnt_t KEY_MAX = cnt_t'(MAX_KEY_BYTES);
  localparam idx_t IDX_TOP = idx_t'(TABLE_SIZE - 1);

  logic [3:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  cnt_t       len_q, len_d;
  idx_t       i_q, i_d;
  idx_t       j_q, j_d;
  idx_t       k_q, k_d;
  byte_t      sa_q, sa_d;
  byte_t      sb_q, sb_d;
  idx_t       t_q, t_d;
  byte_t      text_q, text_d;
  logic       last_q, last_d;
  byte_t      ks_q, ks_d;

  logic       accept;
  cnt_t       cnt_next;
  idx_t       j_sum;
  byte_t      ks_fwd;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // keystream byte after the swap: forward the two freshly written entries
  always_comb begin
    if (t_q == j_q) begin
      ks_fwd = sa_q;
    end else if (t_q == i_q) begin
      ks_fwd = sb_q;
    end else begin
      ks_fwd = perm_rdata_i;
    end
  end

  // sequencer: key load, key scheduling, generator step
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    sa_d       = sa_q;
    sb_d       = sb_q;
    t_d        = t_q;
    text_d     = text_q;
    last_d     = last_q;
    ks_d       = ks_q;
    perm_req_o = '0;
    key_req_o  = '0;
    res_o      = '0;
    cnt_next   = cnt_q;
    j_sum      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_KEY) begin
            // store key byte, drop it once the store is full
            if (cnt_q < KEY_MAX) begin
              key_req_o.we    = 1'b1;
              key_req_o.waddr = cnt_q[IDX_W-1:0];
              key_req_o.wdata = data_byte_i;
              cnt_next        = cnt_q + cnt_t'(1);
            end
            cnt_d = cnt_next;
            if (last_flag_i) begin
              len_d          = cnt_next;
              cnt_d          = '0;
              perm_req_o.clr = 1'b1;
              i_d            = '0;
              j_d            = '0;
              k_d            = '0;
              state_d        = ST_KS_RD;
            end
          end else begin
            i_d              = i_q + idx_t'(1);
            perm_req_o.raddr = i_q + idx_t'(1);
            text_d           = data_byte_i;
            last_d           = last_flag_i;
            state_d          = ST_PG_J;
          end
        end
      end

      ST_KS_RD: begin
        perm_req_o.raddr = i_q;
        key_req_o.raddr  = k_q;
        state_d          = ST_KS_J;
      end

      ST_KS_J: begin
        j_sum            = j_q + perm_rdata_i + key_rdata_i;
        j_d              = j_sum;
        sa_d             = perm_rdata_i;
        perm_req_o.raddr = j_sum;
        state_d          = ST_KS_WN;
      end

      ST_KS_WN: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        state_d          = ST_KS_WJ;
      end

      ST_KS_WJ: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = sa_q;
        i_d              = i_q + idx_t'(1);
        // key index runs modulo the key length
        if ((cnt_t'(k_q) + cnt_t'(1)) == len_q) begin
          k_d = '0;
        end else begin
          k_d = k_q + idx_t'(1);
        end
        if (i_q == IDX_TOP) begin
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_KS_RD;
        end
      end

      ST_PG_J: begin
        j_sum            = j_q + perm_rdata_i;
        j_d              = j_sum;
        sa_d             = perm_rdata_i;
        perm_req_o.raddr = j_sum;
        state_d          = ST_PG_WI;
      end

      ST_PG_WI: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        sb_d             = perm_rdata_i;
        t_d              = sa_q + perm_rdata_i;
        perm_req_o.raddr = sa_q + perm_rdata_i;
        state_d          = ST_PG_KS;
      end

      ST_PG_KS: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = j_q;
        perm_req_o.wdata = sa_q;
        if (out_free_i) begin
          res_o.vld    = 1'b1;
          res_o.cipher = text_q ^ ks_fwd;
          res_o.ks     = ks_fwd;
          res_o.last   = last_q;
          state_d      = ST_IDLE;
        end else begin
          ks_d    = ks_fwd;
          state_d = ST_HOLD;
        end
      end

      ST_HOLD: begin
        if (out_free_i) begin
          res_o.vld    = 1'b1;
          res_o.cipher = text_q ^ ks_q;
          res_o.ks     = ks_q;
          res_o.last   = last_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      len_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // working data
  always_ff @(posedge clk_i) begin
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    t_q    <= t_d;
    text_q <= text_d;
    last_q <= last_d;
    ks_q   <= ks_d;
  end

endmodule

`default_nettype wire

FILE: verif/tb_rc4_stream_cipher.sv
`default_nettype none

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int DIR_ROWS      = 21;
  localparam int RANDOM_WORDS  = 900;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT  = 10;

  // one output word of the engine
  typedef struct packed {
    byte_t cipher;
    byte_t ks;
    logic  last;
  } cipher_word_t;

  // directed row; typed = 1 means the expected word is given here
  typedef struct packed {
    logic         op;
    byte_t        data;
    logic         last;
    logic         typed;
    cipher_word_t want;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_e;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_stall_o;
  logic  opcode_i    = OP_KEY;
  byte_t data_byte_i = 8'h00;
  logic  last_flag_i = 1'b0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  byte_t cipher_byte_o;
  byte_t keystream_byte_o;
  logic  last_out_o;

  rc4_stream_cipher u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .last_flag_i      (last_flag_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cipher_byte_o    (cipher_byte_o),
    .keystream_byte_o (keystream_byte_o),
    .last_out_o       (last_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Directed words: reset-table keystream, the classic "Key"/"Plaintext"
  // vector, one-byte and two-byte keys, extreme data bytes.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TEXT, 8'h00, 1'b0, 1'b1, '{8'h02, 8'h02, 1'b0}},
    '{OP_TEXT, 8'hFF, 1'b1, 1'b1, '{8'hFA, 8'h05, 1'b1}},
    '{OP_TEXT, 8'hA5, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h4B, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h65, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h79, 1'b1, 1'b0, '0},
    '{OP_TEXT, 8'h50, 1'b0, 1'b1, '{8'hBB, 8'hEB, 1'b0}},
    '{OP_TEXT, 8'h6C, 1'b0, 1'b1, '{8'hF3, 8'h9F, 1'b0}},
    '{OP_TEXT, 8'h61, 1'b0, 1'b1, '{8'h16, 8'h77, 1'b0}},
    '{OP_TEXT, 8'h69, 1'b0, 1'b1, '{8'hE8, 8'h81, 1'b0}},
    '{OP_TEXT, 8'h6E, 1'b0, 1'b1, '{8'hD9, 8'hB7, 1'b0}},
    '{OP_TEXT, 8'h74, 1'b0, 1'b1, '{8'h40, 8'h34, 1'b0}},
    '{OP_TEXT, 8'h65, 1'b0, 1'b1, '{8'hAF, 8'hCA, 1'b0}},
    '{OP_TEXT, 8'h78, 1'b0, 1'b1, '{8'h0A, 8'h72, 1'b0}},
    '{OP_TEXT, 8'h74, 1'b1, 1'b1, '{8'hD3, 8'hA7, 1'b1}},
    '{OP_KEY,  8'hFF, 1'b1, 1'b0, '0},
    '{OP_TEXT, 8'h00, 1'b0, 1'b0, '0},
    '{OP_TEXT, 8'hFF, 1'b1, 1'b0, '0},
    '{OP_KEY,  8'h00, 1'b0, 1'b0, '0},
    '{OP_KEY,  8'h80, 1'b1, 1'b0, '0},
    '{OP_TEXT, 8'h55, 1'b0, 1'b0, '0}
  };

  // cipher state mirror
  byte_t perm_s  [256];
  byte_t key_mem [256];
  int    key_len;
  byte_t idx_i;
  byte_t idx_j;

  cipher_word_t cipher_words_q [$];
  int           mismatch_count = 0;
  int           words_sent     = 0;
  int           burst_left     = 8;
  int           cycle_count    = 0;
  stall_mode_e  stall_mode     = STALL_NONE;
  int           stall_phase    = 0;

  // Apply one accepted word to the mirror; text words yield a result.
  task automatic rc4_apply_word(input logic op, input byte_t d, input logic lst,
                                output logic produced, output cipher_word_t w);
    byte_t acc;
    byte_t tmp;
    byte_t ks;
    produced = 1'b0;
    w        = '0;
    if (op == OP_KEY) begin
      // bytes past the key limit are dropped
      if (key_len < MAX_KEY_BYTES) begin
        key_mem[key_len] = d;
        key_len++;
      end
      if (lst) begin
        for (int n = 0; n < TABLE_SIZE; n++) perm_s[n] = byte_t'(n);
        acc = 8'h00;
        for (int n = 0; n < TABLE_SIZE; n++) begin
          acc       = byte_t'(acc + perm_s[n] + key_mem[n % key_len]);
          tmp       = perm_s[n];
          perm_s[n] = perm_s[acc];
          perm_s[acc] = tmp;
        end
        idx_i   = 8'h00;
        idx_j   = 8'h00;
        key_len = 0;
      end
    end else begin
      idx_i         = byte_t'(idx_i + 8'd1);
      idx_j         = byte_t'(idx_j + perm_s[idx_i]);
      tmp           = perm_s[idx_i];
      perm_s[idx_i] = perm_s[idx_j];
      perm_s[idx_j] = tmp;
      ks            = perm_s[byte_t'(perm_s[idx_i] + perm_s[idx_j])];
      w.cipher      = d ^ ks;
      w.ks          = ks;
      w.last        = lst;
      produced      = 1'b1;
    end
  endtask

  // Drive one word, wait for acceptance, then record what it should yield.
  task automatic send_word(input logic op, input byte_t d, input logic lst,
                           input logic typed, input cipher_word_t typed_word);
    logic         produced;
    cipher_word_t predicted;
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= d;
    last_flag_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    rc4_apply_word(op, d, lst, produced, predicted);
    if (produced) cipher_words_q.push_back(typed ? typed_word : predicted);
    // end of burst: drop valid for a random pause, then pick the next burst length
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_key(input int len, input logic close_key);
    for (int k = 0; k < len; k++)
      send_word(OP_KEY, byte_t'($urandom_range(0, 255)),
                close_key && (k == len - 1), 1'b0, '0);
  endtask

  task automatic send_text(input int len);
    for (int k = 0; k < len; k++)
      send_word(OP_TEXT, byte_t'($urandom_range(0, 255)),
                (k == len - 1) || ($urandom_range(0, 15) == 0), 1'b0, '0);
  endtask

  // stop sending until every pending word has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (cipher_words_q.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input cipher_word_t want,
                                 input cipher_word_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t %s: expected cipher %h ks %h last %b, got cipher %h ks %h last %b",
               $time, what, want.cipher, want.ks, want.last,
               seen.cipher, seen.ks, seen.last);
  endtask

  // output checker
  always @(posedge clk_i) begin
    cipher_word_t seen;
    cipher_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{cipher_byte_o, keystream_byte_o, last_out_o};
      if (cipher_words_q.size() == 0) begin
        report_mismatch("unexpected word", '0, seen);
      end else begin
        want = cipher_words_q.pop_front();
        if (want !== seen) report_mismatch("word mismatch", want, seen);
      end
    end
  end

  // receiver stall pattern: phases of no, light, heavy and alternating stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_phase <= 0;
      stall_mode  <= STALL_NONE;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  <= stall_mode_e'($urandom_range(0, 3));
        stall_phase <= $urandom_range(16, 96);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        STALL_NONE:      out_stall_i <= 1'b0;
        STALL_LIGHT:     out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:     out_stall_i <= ($urandom_range(0, 3) != 0);
        STALL_ALTERNATE: out_stall_i <= stall_phase[0];
        default:         out_stall_i <= 1'b0;
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending",
               cycle_count, cipher_words_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    int msg;
    int pick;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      perm_s[n]  = byte_t'(n);
      key_mem[n] = 8'h00;
    end
    key_len = 0;
    idx_i   = 8'h00;
    idx_j   = 8'h00;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++)
      send_word(dir_rows[r].op, dir_rows[r].data, dir_rows[r].last,
                dir_rows[r].typed, dir_rows[r].want);
    drain_results();

    // random messages: mostly key then text, some bare text, split keys
    // and pauses; two keys hit and overrun the key limit
    msg = 0;
    while (words_sent < DIR_ROWS + RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      if (msg == 2)
        send_key(MAX_KEY_BYTES, 1'b1);
      else if (msg == 6)
        send_key($urandom_range(MAX_KEY_BYTES + 1, MAX_KEY_BYTES + 6), 1'b1);
      else if (pick < 7)
        send_key(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16), 1'b1);
      else if (pick == 8)
        send_key($urandom_range(1, 6), 1'b0);
      else if (pick == 9)
        drain_results();
      send_text($urandom_range(1, 24));
      msg++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && cipher_words_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_perm_mem.sv
rtl/rc4_key_mem.sv
rtl/rc4_core.sv
rtl/rc4_stream_cipher.sv
verif/tb_rc4_stream_cipher.sv
